// File: sv/irkd_pkg.sv
// Shared types, constants and helpers for the IR pulse-distance key decoder.
// No dependencies; every other file of the decoder refers to this package.
`timescale 1ns / 1ps

package irkd_pkg;

  // Frame layout.
  localparam int FRAME_BITS      = 32;
  localparam int KEY_FIELD_START = 16;
  localparam int KEY_W           = 8;
  localparam int BITS_W          = 32;
  localparam int IDX_W           = $clog2(BITS_W);
  localparam int POS_W           = 6;

  // Port and register widths.
  localparam int TIME_W     = 32;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int OUT_DATA_W = 8;

  // Fixed lower bound of the zero bit window, exclusive.
  localparam logic [CFG_W-1:0] ZERO_MIN_US = CFG_W'(1000);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_KEY_TABLE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LEAD_MIN_US   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_LEAD_MAX_US   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MIN_US = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MAX_US = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MAX_US   = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN_US    = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MAX_US    = CFG_IDX_W'(7);

  // Register reset values.
  localparam logic [CFG_W-1:0] KEY_TABLE_RST     = CFG_W'(3094);
  localparam logic [CFG_W-1:0] LEAD_MIN_US_RST   = CFG_W'(13000);
  localparam logic [CFG_W-1:0] LEAD_MAX_US_RST   = CFG_W'(14000);
  localparam logic [CFG_W-1:0] REPEAT_MIN_US_RST = CFG_W'(11000);
  localparam logic [CFG_W-1:0] REPEAT_MAX_US_RST = CFG_W'(12000);
  localparam logic [CFG_W-1:0] ZERO_MAX_US_RST   = CFG_W'(1500);
  localparam logic [CFG_W-1:0] ONE_MIN_US_RST    = CFG_W'(2000);
  localparam logic [CFG_W-1:0] ONE_MAX_US_RST    = CFG_W'(2500);

  // Configuration register file.
  typedef struct packed {
    logic [CFG_W-1:0] key_table;
    logic [CFG_W-1:0] lead_min_us;
    logic [CFG_W-1:0] lead_max_us;
    logic [CFG_W-1:0] repeat_min_us;
    logic [CFG_W-1:0] repeat_max_us;
    logic [CFG_W-1:0] zero_max_us;
    logic [CFG_W-1:0] one_min_us;
    logic [CFG_W-1:0] one_max_us;
  } cfg_t;

  // Window hits of one edge interval.
  typedef struct packed {
    logic lead;
    logic rpt;
    logic zero;
    logic one;
  } class_t;

  // One decoded result.
  typedef struct packed {
    logic valid;
    logic key_index;
    logic is_repeat;
  } result_t;

  // Strict window test: lo < v < hi.
  function automatic logic win_hit(logic [TIME_W-1:0] v, logic [CFG_W-1:0] lo,
                                   logic [CFG_W-1:0] hi);
    logic [TIME_W-1:0] lo_x;
    logic [TIME_W-1:0] hi_x;
    lo_x = TIME_W'(lo);
    hi_x = TIME_W'(hi);
    return (v > lo_x) && (v < hi_x);
  endfunction

endpackage

// File: sv/irkd_classify.sv
// Interval computation and window classification for one edge.
// Depends on irkd_pkg for the configuration and classification types.
`timescale 1ns / 1ps

module irkd_classify (
  input  logic [irkd_pkg::TIME_W-1:0] now,
  input  logic [irkd_pkg::TIME_W-1:0] prev_time,
  input  irkd_pkg::cfg_t              cfg,
  output irkd_pkg::class_t            hits
);

  logic [irkd_pkg::TIME_W-1:0] interval;

  // The timestamp wraps, so the interval is taken modulo 2^32.
  assign interval = now - prev_time;

  // Each window is tested on its own; priority is resolved downstream.
  always_comb begin
    hits.lead = irkd_pkg::win_hit(interval, cfg.lead_min_us, cfg.lead_max_us);
    hits.rpt  = irkd_pkg::win_hit(interval, cfg.repeat_min_us, cfg.repeat_max_us);
    hits.zero = irkd_pkg::win_hit(interval, irkd_pkg::ZERO_MIN_US, cfg.zero_max_us);
    hits.one  = irkd_pkg::win_hit(interval, cfg.one_min_us, cfg.one_max_us);
  end

endmodule

// File: sv/irkd_frame.sv
// Frame state of the decoder: previous edge, bit counter, received bits, last key.
// Depends on irkd_pkg; takes window hits from irkd_classify.
`timescale 1ns / 1ps

module irkd_frame (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [irkd_pkg::TIME_W-1:0] now,
  input  irkd_pkg::class_t            hits,
  input  logic [irkd_pkg::CFG_W-1:0]  key_table,
  output logic [irkd_pkg::TIME_W-1:0] prev_time,
  output irkd_pkg::result_t           res
);

  localparam logic [irkd_pkg::POS_W-1:0] LAST_POS = irkd_pkg::POS_W'(irkd_pkg::FRAME_BITS);

  logic                        prev_valid;
  logic                        in_frame;
  logic [irkd_pkg::POS_W-1:0]  bit_position;
  logic [irkd_pkg::BITS_W-1:0] received_bits;
  logic                        last_key;

  logic                        prev_valid_next;
  logic [irkd_pkg::TIME_W-1:0] prev_time_next;
  logic                        in_frame_next;
  logic [irkd_pkg::POS_W-1:0]  bit_position_next;
  logic [irkd_pkg::BITS_W-1:0] received_bits_next;
  logic                        last_key_next;
  logic [irkd_pkg::POS_W-1:0]  pos_inc;
  logic [irkd_pkg::KEY_W-1:0]  field;

  assign pos_inc = bit_position + irkd_pkg::POS_W'(1);
  assign field   = received_bits_next[irkd_pkg::KEY_FIELD_START +: irkd_pkg::KEY_W];

  // Next state for one edge: lead first, then repeat, then a data bit.
  always_comb begin
    prev_valid_next    = 1'b1;
    prev_time_next     = now;
    in_frame_next      = in_frame;
    bit_position_next  = bit_position;
    received_bits_next = received_bits;
    last_key_next      = last_key;
    res                = '0;
    if (prev_valid) begin
      if (hits.lead) begin
        in_frame_next     = 1'b1;
        bit_position_next = '0;
      end else if (hits.rpt) begin
        in_frame_next     = 1'b0;
        bit_position_next = '0;
        res.valid         = 1'b1;
        res.key_index     = last_key;
        res.is_repeat     = 1'b1;
      end else if (in_frame) begin
        // A bit outside both bit windows keeps its old value.
        if (hits.zero) begin
          received_bits_next[bit_position[irkd_pkg::IDX_W-1:0]] = 1'b0;
        end else if (hits.one) begin
          received_bits_next[bit_position[irkd_pkg::IDX_W-1:0]] = 1'b1;
        end
        if (pos_inc >= LAST_POS) begin
          in_frame_next     = 1'b0;
          bit_position_next = '0;
          // Key zero wins when both bytes match.
          if (field == key_table[irkd_pkg::KEY_W-1:0]) begin
            last_key_next = 1'b0;
            res.valid     = 1'b1;
          end else if (field == key_table[2*irkd_pkg::KEY_W-1:irkd_pkg::KEY_W]) begin
            last_key_next = 1'b1;
            res.valid     = 1'b1;
          end
          res.key_index = last_key_next;
        end else begin
          bit_position_next = pos_inc;
        end
      end
    end
  end

  // State registers advance once per processed edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_valid    <= 1'b0;
      prev_time     <= '0;
      in_frame      <= 1'b0;
      bit_position  <= '0;
      received_bits <= '0;
      last_key      <= 1'b0;
    end else if (step) begin
      prev_valid    <= prev_valid_next;
      prev_time     <= prev_time_next;
      in_frame      <= in_frame_next;
      bit_position  <= bit_position_next;
      received_bits <= received_bits_next;
      last_key      <= last_key_next;
    end
  end

  // The bit counter stays below the frame length.
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    bit_position < LAST_POS)
    else $error("bit position out of range");

  // Outside a frame the counter rests at zero.
  a_idle_pos: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> bit_position == '0)
    else $error("bit position nonzero outside a frame");

  // A repeat result always closes the frame.
  a_repeat_ends: assert property (@(posedge clk) disable iff (rst)
    step && res.valid && res.is_repeat |=> !in_frame)
    else $error("frame still open after repeat code");

  // A full-frame result reports the key that is then remembered.
  a_key_kept: assert property (@(posedge clk) disable iff (rst)
    step && res.valid && !res.is_repeat |=> last_key == $past(res.key_index))
    else $error("remembered key differs from reported key");

endmodule

// File: sv/ir_pulse_distance_key_decoder.sv
// Top level of the IR pulse-distance key decoder: ports, configuration, staging.
// Depends on irkd_pkg, irkd_classify and irkd_frame.
// A result reaches the master side through the input register and then the result register.
// Throughput: one edge word per cycle; the input register and the result register
// part the two sides, so the slave side stalls only while a result waits and the next
// edge is held.
// Reset (rst, synchronous): no edge seen, no frame, key zero remembered, registers at defaults.
`timescale 1ns / 1ps

module ir_pulse_distance_key_decoder (
  input  logic                              clk,
  input  logic                              rst,
  // Edge timestamps. tdata: [31:0] edge_time_us.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [irkd_pkg::TIME_W-1:0]       s_axis_tdata,
  // Decoded keys. tdata: [0] key_index, [7:1] zero. tuser: [0] is_repeat.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [irkd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tuser,
  // Configuration writes.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [irkd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [irkd_pkg::CFG_W-1:0]        cfg_data
);

  irkd_pkg::cfg_t              cfg;
  logic                        in_valid;
  logic [irkd_pkg::TIME_W-1:0] in_time;
  logic                        step;
  logic [irkd_pkg::TIME_W-1:0] prev_time;
  irkd_pkg::class_t            hits;
  irkd_pkg::result_t           res;
  logic                        out_key;
  logic                        out_repeat;

  assign cfg_ready = 1'b1;

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_table     <= irkd_pkg::KEY_TABLE_RST;
      cfg.lead_min_us   <= irkd_pkg::LEAD_MIN_US_RST;
      cfg.lead_max_us   <= irkd_pkg::LEAD_MAX_US_RST;
      cfg.repeat_min_us <= irkd_pkg::REPEAT_MIN_US_RST;
      cfg.repeat_max_us <= irkd_pkg::REPEAT_MAX_US_RST;
      cfg.zero_max_us   <= irkd_pkg::ZERO_MAX_US_RST;
      cfg.one_min_us    <= irkd_pkg::ONE_MIN_US_RST;
      cfg.one_max_us    <= irkd_pkg::ONE_MAX_US_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        irkd_pkg::REG_KEY_TABLE:     cfg.key_table     <= cfg_data;
        irkd_pkg::REG_LEAD_MIN_US:   cfg.lead_min_us   <= cfg_data;
        irkd_pkg::REG_LEAD_MAX_US:   cfg.lead_max_us   <= cfg_data;
        irkd_pkg::REG_REPEAT_MIN_US: cfg.repeat_min_us <= cfg_data;
        irkd_pkg::REG_REPEAT_MAX_US: cfg.repeat_max_us <= cfg_data;
        irkd_pkg::REG_ZERO_MAX_US:   cfg.zero_max_us   <= cfg_data;
        irkd_pkg::REG_ONE_MIN_US:    cfg.one_min_us    <= cfg_data;
        irkd_pkg::REG_ONE_MAX_US:    cfg.one_max_us    <= cfg_data;
        default: ;
      endcase
    end
  end

  // An edge is processed once the result register can take its outcome.
  assign step          = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || step;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_time <= s_axis_tdata;
    end
  end

  irkd_classify u_classify (
    .now       (in_time),
    .prev_time (prev_time),
    .cfg       (cfg),
    .hits      (hits)
  );

  irkd_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .now       (in_time),
    .hits      (hits),
    .key_table (cfg.key_table),
    .prev_time (prev_time),
    .res       (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step && res.valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.valid) begin
      out_key    <= res.key_index;
      out_repeat <= res.is_repeat;
    end
  end

  assign m_axis_tdata = {(irkd_pkg::OUT_DATA_W - 1)'(0), out_key};
  assign m_axis_tuser = out_repeat;

  // The slave side stalls only behind a held edge and a waiting result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> in_valid && m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a waiting result");

  // A new result never overwrites one that was not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !step)
    else $error("pending result overwritten");

  // Once an edge is held, it is processed or still held in the next cycle.
  a_edge_kept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !step |=> in_valid && $stable(in_time))
    else $error("held edge lost");

endmodule
